>>> hdl/rmst_pkg.sv
package rmst_pkg;

	// Number of leaves and the node array that holds them.
	localparam int LEAF_COUNT = 1024;
	localparam int NODE_COUNT = 2 * LEAF_COUNT;
	localparam int NODE_W = $clog2(NODE_COUNT);
	// Range pointers must also hold NODE_COUNT itself.
	localparam int PTR_W = NODE_W + 1;

	// Field widths of the item ports.
	localparam int IDX_W = 11;
	localparam int VAL_W = 30;

	// Neutral element of the minimum, also the saturation ceiling.
	localparam logic [VAL_W-1:0] NEUTRAL_VALUE = VAL_W'(1000000000);

	// Codes of the kind field.
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Minimum of two node values.
	function automatic logic [VAL_W-1:0] min_of(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

>>> hdl/range_min_segment_tree.sv
// Range-minimum segment tree over rmst_pkg::LEAF_COUNT leaves, kept in one node RAM.
// Update: writes the leaf, then one sibling read per level up to the root.
// Query: walks up the tree one level at a time, reading up to two nodes per level, then the result register.
// One item is worked at a time; the memory read port sets the per-level cost.
// Reset (arst_n low) starts a clearing pass that fills every node with the neutral
// value; no item is accepted until it ends.
module range_min_segment_tree (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic [rmst_pkg::IDX_W-1:0] left_index,
	input  logic [rmst_pkg::IDX_W-1:0] right_index,
	input  logic [rmst_pkg::VAL_W-1:0] new_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rmst_pkg::VAL_W-1:0] range_minimum
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_Q_TOP,
		ST_Q_LO,
		ST_Q_HI
	} state_t;

	localparam logic [rmst_pkg::NODE_W-1:0] LAST_NODE = rmst_pkg::NODE_W'(rmst_pkg::NODE_COUNT - 1);
	localparam logic [rmst_pkg::NODE_W-1:0] LEAF_BASE = rmst_pkg::NODE_W'(rmst_pkg::LEAF_COUNT);
	localparam logic [rmst_pkg::NODE_W-1:0] ROOT_NODE = rmst_pkg::NODE_W'(1);
	localparam logic [rmst_pkg::PTR_W-1:0] PTR_LEAVES = rmst_pkg::PTR_W'(rmst_pkg::LEAF_COUNT);

	state_t                        state_q;
	logic [rmst_pkg::NODE_W-1:0]   clr_q;
	logic [rmst_pkg::NODE_W-1:0]   node_q;
	logic [rmst_pkg::VAL_W-1:0]    cur_q;
	logic [rmst_pkg::PTR_W-1:0]    lo_q;
	logic [rmst_pkg::PTR_W-1:0]    hi_q;
	logic [rmst_pkg::VAL_W-1:0]    acc_lo_q;
	logic [rmst_pkg::VAL_W-1:0]    acc_hi_q;
	logic                          res_valid_q;
	logic [rmst_pkg::VAL_W-1:0]    res_q;

	logic [rmst_pkg::VAL_W-1:0]    mem [rmst_pkg::NODE_COUNT];
	logic [rmst_pkg::VAL_W-1:0]    rdata_q;
	logic                          mem_we;
	logic [rmst_pkg::NODE_W-1:0]   mem_waddr;
	logic [rmst_pkg::VAL_W-1:0]    mem_wdata;
	logic [rmst_pkg::NODE_W-1:0]   mem_raddr;

	logic                          in_xfer;
	logic                          out_xfer;
	logic                          res_free;
	logic [rmst_pkg::VAL_W-1:0]    sat_value;
	logic [rmst_pkg::NODE_W-1:0]   leaf_node;
	logic                          leaf_ok;
	logic [rmst_pkg::PTR_W-1:0]    lo_start;
	logic [rmst_pkg::PTR_W-1:0]    hi_start;
	logic [rmst_pkg::NODE_W-1:0]   parent;
	logic [rmst_pkg::VAL_W-1:0]    upd_min;
	logic [rmst_pkg::PTR_W-1:0]    lo_inc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign out_valid = res_valid_q;
	assign range_minimum = res_q;
	assign out_xfer = res_valid_q && out_ready;
	// The result register can take a new value once the old one leaves.
	assign res_free = !res_valid_q || out_ready;

	// Input decoding: saturate the value, locate the leaf, clamp the range.
	assign sat_value = (new_value > rmst_pkg::NEUTRAL_VALUE) ? rmst_pkg::NEUTRAL_VALUE : new_value;
	assign leaf_ok = (rmst_pkg::PTR_W'(left_index) < PTR_LEAVES);
	assign leaf_node = rmst_pkg::NODE_W'(left_index) + LEAF_BASE;
	assign lo_start = ((rmst_pkg::PTR_W'(left_index) > PTR_LEAVES) ? PTR_LEAVES
			: rmst_pkg::PTR_W'(left_index)) + PTR_LEAVES;
	assign hi_start = ((rmst_pkg::PTR_W'(right_index) > PTR_LEAVES) ? PTR_LEAVES
			: rmst_pkg::PTR_W'(right_index)) + PTR_LEAVES;

	assign parent = node_q >> 1;
	assign upd_min = rmst_pkg::min_of(cur_q, rdata_q);
	assign lo_inc = lo_q + rmst_pkg::PTR_W'(1);

	// Memory port control for each state.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = rmst_pkg::NEUTRAL_VALUE;
		mem_raddr = node_q ^ ROOT_NODE;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_we = in_xfer && (kind == rmst_pkg::KIND_UPDATE) && leaf_ok;
				mem_waddr = leaf_node;
				mem_wdata = sat_value;
			end
			ST_UPD_RD: begin
				mem_raddr = node_q ^ ROOT_NODE;
			end
			ST_UPD_WR: begin
				mem_we = 1'b1;
				mem_waddr = parent;
				mem_wdata = upd_min;
			end
			ST_Q_TOP: begin
				if (lo_q[0]) begin
					mem_raddr = lo_q[rmst_pkg::NODE_W-1:0];
				end else begin
					mem_raddr = hi_q[rmst_pkg::NODE_W-1:0] - ROOT_NODE;
				end
			end
			ST_Q_LO: begin
				mem_raddr = hi_q[rmst_pkg::NODE_W-1:0] - ROOT_NODE;
			end
			ST_Q_HI: begin
				mem_raddr = node_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Node RAM: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Sequencer for clearing, updates and queries, with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			res_valid_q <= 1'b0;
			node_q <= '0;
			cur_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			acc_lo_q <= '0;
			acc_hi_q <= '0;
			res_q <= '0;
		end else begin
			if (out_xfer) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROOT_NODE;
					if (clr_q == LAST_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						if (kind == rmst_pkg::KIND_UPDATE) begin
							node_q <= leaf_node;
							cur_q <= sat_value;
							if (leaf_ok && (leaf_node != ROOT_NODE)) begin
								state_q <= ST_UPD_RD;
							end
						end else begin
							lo_q <= lo_start;
							hi_q <= hi_start;
							acc_lo_q <= rmst_pkg::NEUTRAL_VALUE;
							acc_hi_q <= rmst_pkg::NEUTRAL_VALUE;
							state_q <= ST_Q_TOP;
						end
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					// The sibling is in rdata; the parent gets the smaller one.
					cur_q <= upd_min;
					node_q <= parent;
					state_q <= (parent == ROOT_NODE) ? ST_IDLE : ST_UPD_RD;
				end
				ST_Q_TOP: begin
					if (lo_q >= hi_q) begin
						// Range exhausted: deliver once the result register is free.
						if (res_free) begin
							res_q <= rmst_pkg::min_of(acc_lo_q, acc_hi_q);
							res_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (lo_q[0]) begin
						state_q <= ST_Q_LO;
					end else if (hi_q[0]) begin
						hi_q <= hi_q - rmst_pkg::PTR_W'(1);
						state_q <= ST_Q_HI;
					end else begin
						lo_q <= lo_q >> 1;
						hi_q <= hi_q >> 1;
					end
				end
				ST_Q_LO: begin
					acc_lo_q <= rmst_pkg::min_of(acc_lo_q, rdata_q);
					if (hi_q[0]) begin
						lo_q <= lo_inc;
						hi_q <= hi_q - rmst_pkg::PTR_W'(1);
						state_q <= ST_Q_HI;
					end else begin
						lo_q <= lo_inc >> 1;
						hi_q <= hi_q >> 1;
						state_q <= ST_Q_TOP;
					end
				end
				ST_Q_HI: begin
					acc_hi_q <= rmst_pkg::min_of(rdata_q, acc_hi_q);
					lo_q <= lo_q >> 1;
					hi_q <= hi_q >> 1;
					state_q <= ST_Q_TOP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
